FILE: sv/leod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leod_pkg
// Shared types, register map, term codes and reset values for the low-pass
// envelope onset detector.
// ----------------------------------------------------------------------------
package leod_pkg;

  // register map, index = byte address / 4
  localparam logic [2:0] REG_B0      = 3'd0;
  localparam logic [2:0] REG_A1      = 3'd1;
  localparam logic [2:0] REG_A2      = 3'd2;
  localparam logic [2:0] REG_THRESH  = 3'd3;
  localparam logic [2:0] REG_ATTACK  = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;
  localparam logic [2:0] REG_MIN_GAP = 3'd6;
  localparam logic [2:0] REG_MAX_ONS = 3'd7;

  localparam int unsigned CFG_AW = 5;

  // register reset values
  localparam logic signed [31:0] RST_B0      = 32'sd213642;
  localparam logic signed [31:0] RST_A1      = -32'sd2104220448;
  localparam logic signed [31:0] RST_A2      = 32'sd1031333324;
  localparam logic [22:0]        RST_THRESH  = 23'd167772;
  localparam logic [23:0]        RST_ATTACK  = 24'd83886;
  localparam logic [23:0]        RST_RELEASE = 24'd8389;
  localparam logic [19:0]        RST_MIN_GAP = 20'd8820;
  localparam logic [15:0]        RST_MAX_ONS = 16'd500;

  // product terms of the shared multiplier
  localparam logic [2:0] TERM_X   = 3'd0;  // b0 * x
  localparam logic [2:0] TERM_X1  = 3'd1;  // b0 * x1, counted twice
  localparam logic [2:0] TERM_X2  = 3'd2;  // b0 * x2
  localparam logic [2:0] TERM_Y1  = 3'd3;  // a1 * y1, subtracted
  localparam logic [2:0] TERM_Y2  = 3'd4;  // a2 * y2, subtracted
  localparam logic [2:0] TERM_ENV = 3'd5;  // envelope diff * gain

  localparam logic [2:0] TERM_LAST_BQ = TERM_Y2;

  typedef struct packed {
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic [22:0]        level_threshold;
    logic [23:0]        attack_gain;
    logic [23:0]        release_gain;
    logic [19:0]        min_gap_samples;
    logic [15:0]        max_onsets;
  } cfg_t;

  typedef struct packed {
    logic       load;      // capture word, clear track state on new_track
    logic       acc_clr;   // zero the filter accumulator
    logic       mul_en;    // issue one product
    logic [2:0] term;      // which product
    logic       stage;     // biquad section 0 or 1
    logic       hist_upd;  // round, saturate, shift section history
    logic       env_upd;   // apply envelope step
    logic       commit;    // detector, counters, result register
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic produce;
    logic out_busy;
  } sts_t;

endpackage

FILE: sv/leod_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leod_ifs
// Valid/ready channels: audio sample words in, onset words out.
// ----------------------------------------------------------------------------
interface leod_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               new_track;

  modport source (output valid, output sample, output new_track, input ready);
  modport sink   (input valid, input sample, input new_track, output ready);
endinterface

interface leod_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] onset_index;
  logic [15:0] onset_number;

  modport source (output valid, output onset_index, output onset_number, input ready);
  modport sink   (input valid, input onset_index, input onset_number, output ready);
endinterface

FILE: sv/lowpass_envelope_onset_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowpass_envelope_onset_detector
// Two cascaded biquad low-pass sections, attack/release envelope follower and
// hysteresis onset detector with minimum gap and onset limit.
// ----------------------------------------------------------------------------
// Sample words are taken one at a time, each accepted only when the previous
//   one is done; the single shared 32x32 multiplier runs eleven products
//   per sample (five per section, one envelope).
// Once the onset limit is reached a word is accepted and dropped unprocessed.
// Reset (rst_n low, synchronous): registers take their defaults, filter,
//   envelope and counters clear, no word pending on either channel.
// ----------------------------------------------------------------------------
module lowpass_envelope_onset_detector
  import leod_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  leod_in_if.sink           in_chan,
  leod_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_chan.ready = in_ready;

  leod_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  leod_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  leod_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_chan.sample),
    .in_new_track     (in_chan.new_track),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_onset_index  (out_chan.onset_index),
    .out_onset_number (out_chan.onset_number)
  );

  // one word at a time: no accept in the cycle after an accept
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready |=> !in_ready)
    else $error("sample word accepted while previous word in flight");

  // commit is only reached below the onset limit
  a_commit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.at_limit)
    else $error("detector commit with onset limit reached");

  // a fired onset shows up on the result channel next cycle
  a_onset_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && sts.produce |=> out_chan.valid)
    else $error("onset fired but no result word presented");

endmodule

FILE: sv/leod_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leod_regs
// APB-style configuration registers with readback.
// ----------------------------------------------------------------------------
module leod_regs
  import leod_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_B0:      cfg_nxt.coef_b0         = pwdata;
        REG_A1:      cfg_nxt.coef_a1         = pwdata;
        REG_A2:      cfg_nxt.coef_a2         = pwdata;
        REG_THRESH:  cfg_nxt.level_threshold = pwdata[22:0];
        REG_ATTACK:  cfg_nxt.attack_gain     = pwdata[23:0];
        REG_RELEASE: cfg_nxt.release_gain    = pwdata[23:0];
        REG_MIN_GAP: cfg_nxt.min_gap_samples = pwdata[19:0];
        REG_MAX_ONS: cfg_nxt.max_onsets      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_B0:      prdata = cfg_r.coef_b0;
      REG_A1:      prdata = cfg_r.coef_a1;
      REG_A2:      prdata = cfg_r.coef_a2;
      REG_THRESH:  prdata = {9'd0, cfg_r.level_threshold};
      REG_ATTACK:  prdata = {8'd0, cfg_r.attack_gain};
      REG_RELEASE: prdata = {8'd0, cfg_r.release_gain};
      REG_MIN_GAP: prdata = {12'd0, cfg_r.min_gap_samples};
      REG_MAX_ONS: prdata = {16'd0, cfg_r.max_onsets};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_b0         <= RST_B0;
      cfg_r.coef_a1         <= RST_A1;
      cfg_r.coef_a2         <= RST_A2;
      cfg_r.level_threshold <= RST_THRESH;
      cfg_r.attack_gain     <= RST_ATTACK;
      cfg_r.release_gain    <= RST_RELEASE;
      cfg_r.min_gap_samples <= RST_MIN_GAP;
      cfg_r.max_onsets      <= RST_MAX_ONS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/leod_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leod_ctrl
// Sequencer: steps the shared multiplier through both biquad sections and the
// envelope product, then commits the detector.
// ----------------------------------------------------------------------------
module leod_ctrl
  import leod_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHK   = 11'b000_0000_0010,
    ST_S1MAC = 11'b000_0000_0100,
    ST_S1END = 11'b000_0000_1000,
    ST_S1OUT = 11'b000_0001_0000,
    ST_S2MAC = 11'b000_0010_0000,
    ST_S2END = 11'b000_0100_0000,
    ST_S2OUT = 11'b000_1000_0000,
    ST_EMUL  = 11'b001_0000_0000,
    ST_EACC  = 11'b010_0000_0000,
    ST_DET   = 11'b100_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.at_limit) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.acc_clr = 1'b1;
          step_nxt    = TERM_X;
          state_nxt   = ST_S1MAC;
        end
      end
      ST_S1MAC: begin
        cmd.mul_en = 1'b1;
        cmd.term   = step_r;
        if (step_r == TERM_LAST_BQ) state_nxt = ST_S1END;
        else                        step_nxt  = step_r + 3'd1;
      end
      ST_S1END: state_nxt = ST_S1OUT;
      ST_S1OUT: begin
        cmd.hist_upd = 1'b1;
        cmd.acc_clr  = 1'b1;
        step_nxt     = TERM_X;
        state_nxt    = ST_S2MAC;
      end
      ST_S2MAC: begin
        cmd.stage  = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.term   = step_r;
        if (step_r == TERM_LAST_BQ) state_nxt = ST_S2END;
        else                        step_nxt  = step_r + 3'd1;
      end
      ST_S2END: begin
        cmd.stage = 1'b1;
        state_nxt = ST_S2OUT;
      end
      ST_S2OUT: begin
        cmd.stage    = 1'b1;
        cmd.hist_upd = 1'b1;
        state_nxt    = ST_EMUL;
      end
      ST_EMUL: begin
        cmd.mul_en = 1'b1;
        cmd.term   = TERM_ENV;
        state_nxt  = ST_EACC;
      end
      ST_EACC: begin
        cmd.env_upd = 1'b1;
        state_nxt   = ST_DET;
      end
      ST_DET: begin
        // hold while an onset would fire and the previous onset word is still unread
        if (!(sts.produce && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= TERM_X;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: sv/leod_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leod_dp
// Datapath: section histories, shared 32x32 multiplier and accumulator,
// envelope follower, hysteresis detector, counters and result register.
// ----------------------------------------------------------------------------
module leod_dp
  import leod_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic signed [15:0] in_sample,
  input  logic               in_new_track,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_onset_index,
  output logic [15:0]        out_onset_number
);

  localparam logic signed [51:0] RND_HALF = 52'sd8192;
  localparam logic signed [51:0] Y_MAX    = 52'sh0_0000_7FFF_FFFF;
  localparam logic signed [51:0] Y_MIN    = -52'sh0_0000_8000_0000;

  logic signed [15:0] smp_r;
  logic signed [31:0] x1_r [2];
  logic signed [31:0] x2_r [2];
  logic signed [31:0] y1_r [2];
  logic signed [31:0] y2_r [2];
  logic signed [31:0] y_r;
  logic signed [63:0] p_r;
  logic [2:0]         term_d_r;
  logic               pv_r;
  logic signed [51:0] acc_r, acc_nxt;
  logic [23:0]        env_r;
  logic               trans_r, havep_r;
  logic [31:0]        prev_r, cnt_r;
  logic [15:0]        ons_r;
  logic               out_valid_r;
  logic [31:0]        out_idx_r;
  logic [15:0]        out_num_r;

  logic signed [31:0] x_in, op_a, op_b;
  logic signed [47:0] p_sh;
  logic signed [51:0] p_ext, rnd, ysh;
  logic signed [31:0] y_sat;
  logic signed [32:0] y_wide, mag;
  logic [23:0]        rect, gain;
  logic signed [24:0] diff;
  logic signed [25:0] env_sum, delta;
  logic [23:0]        env_nxt;
  logic               arm, gap_ok, fire, disarm;
  logic [31:0]        gap;

  // section input: sample scaled to Q8.24, or the first section's output
  assign x_in = cmd.stage ? y_r : {{7{smp_r[15]}}, smp_r, 9'd0};

  // envelope step operands
  assign y_wide = {y_r[31], y_r};
  assign mag    = y_wide[32] ? -y_wide : y_wide;
  assign rect   = (|mag[32:25]) ? 24'hFF_FFFF : mag[24:1];
  assign gain   = (rect > env_r) ? cfg.attack_gain : cfg.release_gain;
  assign diff   = $signed({1'b0, rect}) - $signed({1'b0, env_r});

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.term)
      TERM_X:   begin op_a = cfg.coef_b0; op_b = x_in;             end
      TERM_X1:  begin op_a = cfg.coef_b0; op_b = x1_r[cmd.stage];  end
      TERM_X2:  begin op_a = cfg.coef_b0; op_b = x2_r[cmd.stage];  end
      TERM_Y1:  begin op_a = cfg.coef_a1; op_b = y1_r[cmd.stage];  end
      TERM_Y2:  begin op_a = cfg.coef_a2; op_b = y2_r[cmd.stage];  end
      TERM_ENV: begin op_a = {{7{diff[24]}}, diff}; op_b = {8'd0, gain}; end
      default: ;
    endcase
  end

  // floor to 2^-38 and sign extend into the accumulator
  assign p_sh  = p_r[63:16];
  assign p_ext = {{4{p_sh[47]}}, p_sh};

  always_comb begin
    acc_nxt = acc_r;
    if (pv_r) begin
      case (term_d_r)
        TERM_X, TERM_X2:  acc_nxt = acc_r + p_ext;
        TERM_X1:          acc_nxt = acc_r + (p_ext <<< 1);
        TERM_Y1, TERM_Y2: acc_nxt = acc_r - p_ext;
        default: ;
      endcase
    end
    if (cmd.acc_clr) acc_nxt = '0;
  end

  // round to Q8.24 and saturate
  assign rnd = acc_r + RND_HALF;
  assign ysh = rnd >>> 14;
  always_comb begin
    if (ysh > Y_MAX)      y_sat = 32'sh7FFF_FFFF;
    else if (ysh < Y_MIN) y_sat = -32'sh8000_0000;
    else                  y_sat = ysh[31:0];
  end

  // envelope update, floored product and clamp to 24 bits
  assign delta   = p_r[49:24];
  assign env_sum = $signed({2'b00, env_r}) + delta;
  always_comb begin
    if (env_sum[25])      env_nxt = 24'd0;
    else if (env_sum[24]) env_nxt = 24'hFF_FFFF;
    else                  env_nxt = env_sum[23:0];
  end

  // hysteresis detector
  assign gap    = cnt_r - prev_r;
  assign arm    = !trans_r && (env_r > {1'b0, cfg.level_threshold});
  assign gap_ok = !havep_r || (gap > {12'd0, cfg.min_gap_samples});
  assign fire   = arm && gap_ok;
  assign disarm = trans_r && (env_r < {2'b00, cfg.level_threshold[22:1]});

  assign sts.at_limit = (ons_r >= cfg.max_onsets);
  assign sts.produce  = fire;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_onset_index  = out_idx_r;
  assign out_onset_number = out_num_r;

  // multiplier stage and payload registers
  always_ff @(posedge clk) begin
    p_r      <= op_a * op_b;
    term_d_r <= cmd.term;
    if (cmd.load) smp_r <= in_sample;
    if (cmd.hist_upd) y_r <= y_sat;
    if (cmd.commit && fire) begin
      out_idx_r <= cnt_r;
      out_num_r <= ons_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r  <= cmd.mul_en;
      acc_r <= acc_nxt;
      if (cmd.commit && fire) out_valid_r <= 1'b1;
      else if (out_ready)     out_valid_r <= 1'b0;
    end
  end

  // track state: cleared by reset and by a word that starts a new track
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && in_new_track)) begin
      for (int i = 0; i < 2; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
      env_r   <= '0;
      trans_r <= 1'b0;
      havep_r <= 1'b0;
      prev_r  <= '0;
      cnt_r   <= '0;
      ons_r   <= '0;
    end else begin
      if (cmd.hist_upd) begin
        x2_r[cmd.stage] <= x1_r[cmd.stage];
        x1_r[cmd.stage] <= x_in;
        y2_r[cmd.stage] <= y1_r[cmd.stage];
        y1_r[cmd.stage] <= y_sat;
      end
      if (cmd.env_upd) env_r <= env_nxt;
      if (cmd.commit) begin
        if (arm) begin
          trans_r <= 1'b1;
          if (gap_ok) begin
            ons_r   <= ons_r + 16'd1;
            prev_r  <= cnt_r;
            havep_r <= 1'b1;
          end
        end else if (disarm) begin
          trans_r <= 1'b0;
        end
        if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
      end
    end
  end

endmodule
